/* design/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg - shared types and constants for the positional ordered list
// Capacity, count and index widths, request and status codes, cell commands.
// ----------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int ECNT_W   = 6;
  localparam int CMP_W    = 8;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_LIST      = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* design/pol_cell.sv */
// ----------------------------------------------------------------------------
// pol_cell - one storage slot of the list
// Takes its neighbor's value on insert shifts, delete shifts and rotations.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_cell
  import pol_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic [IDX_W-1:0]        cell_idx,
  input  wire cell_cmd_t               cmd,
  input  wire logic signed [VAL_W-1:0] left_value,
  input  wire logic signed [VAL_W-1:0] right_value,
  input  wire logic signed [VAL_W-1:0] wrap_value,
  output logic signed [VAL_W-1:0]      value
);

  logic signed [VAL_W-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd.op)
      OP_INSERT: begin
        if (cell_idx == cmd.idx) begin
          value_next = cmd.value;
        end else if (cell_idx > cmd.idx) begin
          value_next = left_value;
        end
      end
      OP_DELETE: begin
        if (cell_idx >= cmd.idx) begin
          value_next = right_value;
        end
      end
      OP_ROTATE: begin
        // tail slot takes the head value, slots before it shift toward the head
        if (cell_idx == cmd.idx) begin
          value_next = wrap_value;
        end else if (cell_idx < cmd.idx) begin
          value_next = right_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

/* design/positional_ordered_list.sv */
// ----------------------------------------------------------------------------
// positional_ordered_list - ordered list with positional insert and delete
// Row of shift cells plus request control and a registered result stage.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (low bit up)                  tlast
//  s_axis   in   req_type[2:0] item_value[34:3] pos[40:35]  -
//  m_axis   out  status[1:0] count[7:2] read_value[39:8]    last_item
//
//  Updates shift all cells in parallel in the accept cycle.
//  A list request rotates the row through cell 0 to emit count results, one
//  per cycle unless stalled; no new transaction is taken until the run ends.
//  Synchronous reset empties the list; cell contents are not cleared.
//  A stalled output holds the result register and pauses the rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list
  import pol_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // req_type, item_value, position, zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // status, element_count, read_value
  output logic             m_tlast    // last_item
);

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        remaining, remaining_next;
  logic [1:0]              out_status, out_status_next;
  logic [ECNT_W-1:0]       out_count, out_count_next;
  logic signed [VAL_W-1:0] out_value, out_value_next;
  logic                    out_last, out_last_next;
  logic                    out_load;
  logic                    out_free;
  logic                    accept;
  cell_cmd_t               cmd;

  logic [2:0]              req_type;
  logic signed [VAL_W-1:0] item_value;
  logic [POS_W-1:0]        position;
  logic [CMP_W-1:0]        pos_w, cnt_w;
  logic                    full, empty;

  logic signed [VAL_W-1:0] cell_value [CAPACITY];

  assign req_type   = s_tdata[2:0];
  assign item_value = s_tdata[34:3];
  assign position   = s_tdata[40:35];

  assign pos_w = CMP_W'(position);
  assign cnt_w = CMP_W'(count);
  assign full  = (count >= CNT_W'(CAPACITY));
  assign empty = (count == '0);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VAL_W-1:0] left_v, right_v;
      if (g == 0) begin : g_head
        assign left_v = '0;
      end else begin : g_mid_l
        assign left_v = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign right_v = '0;
      end else begin : g_mid_r
        assign right_v = cell_value[g+1];
      end
      pol_cell u_cell (
        .clk         (clk),
        .cell_idx    (IDX_W'(g)),
        .cmd         (cmd),
        .left_value  (left_v),
        .right_value (right_v),
        .wrap_value  (cell_value[0]),
        .value       (cell_value[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_LIST && !empty) begin
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        if (out_free && remaining == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '{op: OP_HOLD, idx: '0, value: item_value};
    count_next      = count;
    remaining_next  = remaining;
    out_load        = 1'b0;
    out_status_next = ST_OK;
    out_value_next  = '0;
    out_last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (req_type)
            REQ_INS_FRONT, REQ_INS_BACK: begin
              if (full) begin
                out_status_next = ST_FULL;
              end else begin
                cmd.op     = OP_INSERT;
                cmd.idx    = (req_type == REQ_INS_FRONT) ? '0 : IDX_W'(count);
                count_next = count + CNT_W'(1);
              end
            end
            REQ_INS_AT: begin
              if (position == '0 || pos_w > cnt_w + CMP_W'(1)) begin
                out_status_next = ST_BADPOS;
              end else if (full) begin
                out_status_next = ST_FULL;
              end else begin
                cmd.op     = OP_INSERT;
                cmd.idx    = IDX_W'(position - POS_W'(1));
                count_next = count + CNT_W'(1);
              end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK: begin
              if (empty) begin
                out_status_next = ST_EMPTY;
              end else begin
                cmd.op     = OP_DELETE;
                cmd.idx    = (req_type == REQ_DEL_FRONT) ? '0 : IDX_W'(count - CNT_W'(1));
                count_next = count - CNT_W'(1);
              end
            end
            REQ_DEL_AT: begin
              if (empty) begin
                out_status_next = ST_EMPTY;
              end else if (position == '0 || pos_w > cnt_w) begin
                out_status_next = ST_BADPOS;
              end else begin
                cmd.op     = OP_DELETE;
                cmd.idx    = IDX_W'(position - POS_W'(1));
                count_next = count - CNT_W'(1);
              end
            end
            REQ_LIST: begin
              if (empty) begin
                out_status_next = ST_EMPTY;
              end else begin
                out_load       = 1'b0;
                remaining_next = count;
              end
            end
            default: out_status_next = ST_OK;
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_value_next = cell_value[0];
          out_last_next  = (remaining == CNT_W'(1));
          cmd.op         = OP_ROTATE;
          cmd.idx        = IDX_W'(count - CNT_W'(1));
          remaining_next = remaining - CNT_W'(1);
        end
      end
      default: out_load = 1'b0;
    endcase
    out_count_next = ECNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= out_status_next;
      out_count  <= out_count_next;
      out_value  <= out_value_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tdata = {out_value, out_count, out_status};
  assign m_tlast = out_last;

endmodule

`default_nettype wire
